[src/mdu_pkg.sv]
// shared constants and types for the masked depth unprojection block
// no dependencies
package mdu_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int IN_COORD_W     = 12;
  localparam int LABEL_W        = 8;
  localparam int RAW_W          = 16;
  localparam int CFG_W          = 24;
  localparam int FOCAL_W        = 16;
  localparam int Z_W            = 24;
  localparam int ZFULL_W        = 32;
  localparam int XY_W           = 25;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 80;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LABEL = 3'd0,
    REG_Z_SCALE      = 3'd1,
    REG_MIN_DEPTH    = 3'd2,
    REG_MAX_DEPTH    = 3'd3,
    REG_FOCAL_X      = 3'd4,
    REG_FOCAL_Y      = 3'd5,
    REG_CENTER_X     = 3'd6,
    REG_CENTER_Y     = 3'd7
  } cfg_reg_t;

endpackage

[src/masked_depth_unprojection.sv]
// masked pinhole depth back-projection, fully pipelined top level
// depends on mdu_pkg
//
// One pixel item enters per clock. Stage 1 scales the raw depth (16x24
// multiply) and forms the signed column/row offsets from the principal
// point; stage 2 applies the label, zero-depth and depth-range tests and
// multiplies each offset by z; then a restoring divider with one quotient
// bit per stage (PW = 16-bit offset plus 24-bit z, 40 stages) divides each
// product by its focal length; a last stage saturates x and y.
// Throughput is one item per cycle unless the output stalls. Rejected pixels
// travel as bubbles and give no output item. Backpressure from the master
// side freezes the whole pipeline; nothing is lost or repeated.
module masked_depth_unprojection #(
  parameter int COORD_BITS = mdu_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: pixel_col[11:0], pixel_row[23:12], mask_label[31:24], depth_sample[47:32]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mdu_pkg::IN_TDATA_W-1:0]    s_tdata,
  // tdata: point_x[24:0], point_y[49:25], point_z[73:50], zero fill
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mdu_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdu_pkg::CFG_W-1:0]         cfg_data
);

  // coordinate bits actually used: the low COORD_BITS, at most 12, of a 12-bit field
  localparam int UW = (COORD_BITS < mdu_pkg::IN_COORD_W) ? COORD_BITS : mdu_pkg::IN_COORD_W;
  localparam int CW = UW + 4;                         // coordinate in q.4
  localparam int DW = (CW > mdu_pkg::FOCAL_W) ? CW : mdu_pkg::FOCAL_W;
  localparam int PW = DW + mdu_pkg::Z_W;              // offset times z
  localparam int FW = mdu_pkg::FOCAL_W;

  // configuration registers
  logic [mdu_pkg::LABEL_W-1:0] target_label;
  logic [mdu_pkg::CFG_W-1:0]   z_scale, min_depth, max_depth;
  logic [FW-1:0]               focal[2];
  logic [FW-1:0]               center[2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_label <= 8'd1;
      z_scale      <= 24'd16777;
      min_depth    <= 24'd6554;
      max_depth    <= 24'd131072;
      focal[0]     <= 16'd9600;
      focal[1]     <= 16'd9600;
      center[0]    <= 16'd5120;
      center[1]    <= 16'd3840;
    end else if (cfg_valid) begin
      unique case (mdu_pkg::cfg_reg_t'(cfg_index))
        mdu_pkg::REG_TARGET_LABEL: target_label <= cfg_data[7:0];
        mdu_pkg::REG_Z_SCALE:      z_scale      <= cfg_data;
        mdu_pkg::REG_MIN_DEPTH:    min_depth    <= cfg_data;
        mdu_pkg::REG_MAX_DEPTH:    max_depth    <= cfg_data;
        mdu_pkg::REG_FOCAL_X:      focal[0]     <= cfg_data[15:0];
        mdu_pkg::REG_FOCAL_Y:      focal[1]     <= cfg_data[15:0];
        mdu_pkg::REG_CENTER_X:     center[0]    <= cfg_data[15:0];
        mdu_pkg::REG_CENTER_Y:     center[1]    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input fields
  logic [UW-1:0] in_coord[2];
  logic [7:0]    in_label;
  logic [15:0]   in_raw;
  assign in_coord[0] = s_tdata[UW-1:0];
  assign in_coord[1] = s_tdata[mdu_pkg::IN_COORD_W+UW-1:mdu_pkg::IN_COORD_W];
  assign in_label    = s_tdata[31:24];
  assign in_raw      = s_tdata[47:32];

  // stage 1: depth scaling and offsets
  logic                        v1;
  logic                        ok1;
  logic [mdu_pkg::ZFULL_W-1:0] zf1;
  logic [DW-1:0]               dmag1[2];
  logic                        neg1[2];

  logic [39:0]   zprod;
  logic [DW-1:0] cext[2], kext[2];
  assign zprod = {24'd0, in_raw} * {16'd0, z_scale};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      cext[a] = DW'({in_coord[a], 4'b0000});
      kext[a] = DW'(center[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      ok1 <= (in_label == target_label) && (in_raw != 16'd0);
      zf1 <= zprod[39:8];
      for (int a = 0; a < 2; a++) begin
        neg1[a]  <= cext[a] < kext[a];
        dmag1[a] <= (cext[a] < kext[a]) ? kext[a] - cext[a] : cext[a] - kext[a];
      end
    end
  end

  // stage 2: acceptance test and offset times z; stage 0 of the divider
  logic            dv[PW+1];
  logic [23:0]     dz[PW+1];
  logic [PW-1:0]   num[2][PW+1];
  logic [FW-1:0]   rem[2][PW+1];
  logic [PW-1:0]   quo[2][PW+1];
  logic            dneg[2][PW+1];
  logic            dzero[2][PW+1];

  logic keep1;
  assign keep1 = v1 && ok1 && (zf1 >= 32'(min_depth)) && (zf1 <= 32'(max_depth));

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= keep1;
    if (en) begin
      dz[0] <= zf1[23:0];
      for (int a = 0; a < 2; a++) begin
        num[a][0]   <= {{(PW-DW){1'b0}}, dmag1[a]} * {{DW{1'b0}}, zf1[23:0]};
        rem[a][0]   <= '0;
        quo[a][0]   <= '0;
        dneg[a][0]  <= neg1[a];
        dzero[a][0] <= (dmag1[a] == '0) || (zf1[23:0] == 24'd0);
      end
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < PW; k++) begin : g_div
    logic [FW:0] trial[2];
    logic        ge[2];
    always_comb begin
      for (int a = 0; a < 2; a++) begin
        trial[a] = {rem[a][k], num[a][k][PW-1]};
        ge[a]    = trial[a] >= {1'b0, focal[a]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
      if (en) begin
        dz[k+1] <= dz[k];
        for (int a = 0; a < 2; a++) begin
          rem[a][k+1]   <= ge[a] ? FW'(trial[a] - {1'b0, focal[a]}) : trial[a][FW-1:0];
          num[a][k+1]   <= num[a][k] << 1;
          quo[a][k+1]   <= {quo[a][k][PW-2:0], ge[a]};
          dneg[a][k+1]  <= dneg[a][k];
          dzero[a][k+1] <= dzero[a][k];
        end
      end
    end
  end

  // last stage: zero focal, saturation and sign
  localparam logic [PW-1:0] POS_MAX = PW'(25'h0FF_FFFF);
  localparam logic [PW-1:0] NEG_MAG = PW'(25'h100_0000);

  logic [24:0] xy_next[2];
  logic [24:0] xy[2];
  logic [23:0] zo;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      logic [PW-1:0] q;
      q = quo[a][PW];
      if (focal[a] == '0) q = dneg[a][PW] ? NEG_MAG : POS_MAX;
      if (dzero[a][PW]) begin
        xy_next[a] = '0;
      end else if (dneg[a][PW]) begin
        if (q > NEG_MAG) q = NEG_MAG;
        xy_next[a] = 25'(~q + 1'b1);
      end else begin
        if (q > POS_MAX) q = POS_MAX;
        xy_next[a] = q[24:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv[PW];
    if (en) begin
      xy[0] <= xy_next[0];
      xy[1] <= xy_next[1];
      zo    <= dz[PW];
    end
  end

  assign m_tdata = {6'd0, zo, xy[1], xy[0]};

  // checks
  a_ready_follows_stall: assert property (@(posedge clk) s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not track output stall");
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_z_in_range: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[73:50] >= min_depth) && (m_tdata[73:50] <= max_depth))
    else $error("emitted depth outside configured range");

endmodule

[sim/tb_top.sv]
// self-checking bench for masked_depth_unprojection: a directed table, then random pixel phases
// depends on mdu_pkg and masked_depth_unprojection
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 175;
  localparam logic [63:0] XY_POS_MAX = 64'd16777215;
  localparam logic [63:0] XY_NEG_MAG = 64'd16777216;

  typedef struct {
    logic [7:0]  label;
    logic [23:0] scale;
    logic [23:0] zmin;
    logic [23:0] zmax;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] cx;
    logic [15:0] cy;
  } cam_cfg_t;

  typedef struct {
    logic [24:0] x;
    logic [24:0] y;
    logic [23:0] z;
  } point_t;

  typedef struct {
    int          cfg_set;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  label;
    logic [15:0] raw;
    bit          typed;   // expectation written out below instead of predicted
    bit          hit;
    point_t      pt;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [mdu_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mdu_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mdu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mdu_pkg::CFG_W-1:0] cfg_data = '0;

  masked_depth_unprojection u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bench copy of the camera registers, updated on each accepted config write
  cam_cfg_t cam;
  point_t   pending_points[$];
  int       mismatches = 0;

  // per-item hints set by the pixel driver, read when the item is accepted
  bit     cur_typed = 1'b0;
  bit     cur_hit = 1'b0;
  point_t cur_pt;

  // receiver controls
  int rx_stall = 0;
  bit draining = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int tx_idle = 0;
  int idle_cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // one axis of the back-projection: (coord*16 - center) * z / focal, saturated
  function automatic logic [24:0] back_project(input logic [11:0] coord,
                                               input logic [15:0] center,
                                               input logic [63:0] z,
                                               input logic [15:0] focal);
    logic [63:0] c;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    bit neg;
    c = 64'(coord) << 4;
    neg = c < 64'(center);
    mag = neg ? 64'(center) - c : c - 64'(center);
    prod = mag * z;
    if (prod == 0) return '0;
    // zero focal length saturates toward the sign of the offset
    if (focal == 0) q = neg ? XY_NEG_MAG : XY_POS_MAX;
    else q = prod / 64'(focal);
    if (neg) begin
      if (q > XY_NEG_MAG) q = XY_NEG_MAG;
      q = 64'd0 - q;
      return q[24:0];
    end
    if (q > XY_POS_MAX) q = XY_POS_MAX;
    return q[24:0];
  endfunction

  // expected point for one pixel; returns 0 when the pixel is masked out
  function automatic bit unproject_pixel(input logic [mdu_pkg::IN_TDATA_W-1:0] px,
                                         output point_t pt);
    logic [63:0] z;
    pt = '{default: '0};
    if (px[31:24] != cam.label) return 1'b0;
    if (px[47:32] == 0) return 1'b0;
    z = (64'(px[47:32]) * 64'(cam.scale)) >> 8;
    // range test at full width; an inverted range rejects everything
    if (z < 64'(cam.zmin) || z > 64'(cam.zmax)) return 1'b0;
    pt.x = back_project(px[11:0], cam.cx, z, cam.fx);
    pt.y = back_project(px[23:12], cam.cy, z, cam.fy);
    pt.z = z[23:0];
    return 1'b1;
  endfunction

  // scoreboard: config writes, accepted pixels and returned points at each edge
  always @(posedge clk) begin
    point_t pt;
    point_t want;
    bit hit;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (mdu_pkg::cfg_reg_t'(cfg_index))
          mdu_pkg::REG_TARGET_LABEL: cam.label = cfg_data[7:0];
          mdu_pkg::REG_Z_SCALE:      cam.scale = cfg_data;
          mdu_pkg::REG_MIN_DEPTH:    cam.zmin = cfg_data;
          mdu_pkg::REG_MAX_DEPTH:    cam.zmax = cfg_data;
          mdu_pkg::REG_FOCAL_X:      cam.fx = cfg_data[15:0];
          mdu_pkg::REG_FOCAL_Y:      cam.fy = cfg_data[15:0];
          mdu_pkg::REG_CENTER_X:     cam.cx = cfg_data[15:0];
          mdu_pkg::REG_CENTER_Y:     cam.cy = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (cur_typed) begin
          hit = cur_hit;
          pt = cur_pt;
        end else begin
          hit = unproject_pixel(s_tdata, pt);
        end
        if (hit) pending_points.insert(pending_points.size(), pt);
      end
      if (m_tvalid && m_tready) begin
        if (pending_points.size() == 0) begin
          report("unexpected point", m_tdata[31:0], '0);
        end else begin
          want = pending_points.pop_front();
          if (m_tdata[24:0] != want.x) report("point_x", m_tdata[24:0], want.x);
          if (m_tdata[49:25] != want.y) report("point_y", m_tdata[49:25], want.y);
          if (m_tdata[73:50] != want.z) report("point_z", m_tdata[73:50], want.z);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: one long hold-off on request, forced ready while draining, else random stalls
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= draining || ($urandom_range(99) >= rx_stall);
      end
    end
  end

  task automatic cfg_write(input mdu_pkg::cfg_reg_t idx, input logic [mdu_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input cam_cfg_t c);
    cfg_write(mdu_pkg::REG_TARGET_LABEL, 24'(c.label));
    cfg_write(mdu_pkg::REG_Z_SCALE, c.scale);
    cfg_write(mdu_pkg::REG_MIN_DEPTH, c.zmin);
    cfg_write(mdu_pkg::REG_MAX_DEPTH, c.zmax);
    cfg_write(mdu_pkg::REG_FOCAL_X, 24'(c.fx));
    cfg_write(mdu_pkg::REG_FOCAL_Y, 24'(c.fy));
    cfg_write(mdu_pkg::REG_CENTER_X, 24'(c.cx));
    cfg_write(mdu_pkg::REG_CENTER_Y, 24'(c.cy));
  endtask

  // wait for every pending point, then let rejected pixels clear the pipeline
  task automatic settle();
    draining = 1'b1;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    draining = 1'b0;
  endtask

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [7:0] label, input logic [15:0] raw);
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {raw, label, row, col};
    do @(posedge clk); while (!s_tready);
  endtask

  cam_cfg_t cfg_sets [4];
  pixel_row_t pixel_table [$];

  task automatic add_row(input pixel_row_t r);
    pixel_table.insert(pixel_table.size(), r);
  endtask

  initial begin
    int cur_set;
    cam_cfg_t rc;
    logic [7:0] lbl;
    logic [15:0] raw;

    // reset values, extremes, zero focal lengths, inverted depth range
    cfg_sets[0] = '{8'd1, 24'd16777, 24'd6554, 24'd131072, 16'd9600, 16'd9600, 16'd5120, 16'd3840};
    cfg_sets[1] = '{8'd255, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 16'd16, 16'hFFFF, 16'd0, 16'hFFFF};
    cfg_sets[2] = '{8'd0, 24'd16777, 24'd0, 24'hFFFFFF, 16'd0, 16'd0, 16'd5120, 16'd3840};
    cfg_sets[3] = '{8'd1, 24'd16777, 24'd200000, 24'd100000, 16'd9600, 16'd9600, 16'd5120, 16'd3840};
    cam = cfg_sets[0];

    // label mismatch, zero depth, center pixel, depth just below and above min, too far
    add_row('{0, 12'd320, 12'd240, 8'd0, 16'd1000, 1, 0, '{0, 0, 0}});
    add_row('{0, 12'd320, 12'd240, 8'd1, 16'd0, 1, 0, '{0, 0, 0}});
    add_row('{0, 12'd320, 12'd240, 8'd1, 16'd1000, 1, 1, '{0, 0, 24'd65535}});
    add_row('{0, 12'd320, 12'd240, 8'd1, 16'd100, 1, 0, '{0, 0, 0}});
    add_row('{0, 12'd320, 12'd240, 8'd1, 16'd101, 1, 1, '{0, 0, 24'd6619}});
    add_row('{0, 12'd320, 12'd240, 8'd1, 16'hFFFF, 1, 0, '{0, 0, 0}});
    add_row('{0, 12'd0, 12'd0, 8'd1, 16'd5000, 0, 0, '{0, 0, 0}});
    add_row('{0, 12'hFFF, 12'hFFF, 8'd1, 16'd7000, 0, 0, '{0, 0, 0}});
    add_row('{0, 12'd100, 12'd400, 8'd1, 16'd1500, 0, 0, '{0, 0, 0}});
    // extremes: saturation in both directions
    add_row('{1, 12'd0, 12'd0, 8'd255, 16'd0, 1, 0, '{0, 0, 0}});
    add_row('{1, 12'hFFF, 12'd0, 8'd255, 16'd1, 0, 0, '{0, 0, 0}});
    add_row('{1, 12'd0, 12'hFFF, 8'd255, 16'd256, 0, 0, '{0, 0, 0}});
    add_row('{1, 12'hFFF, 12'hFFF, 8'd255, 16'd1, 0, 0, '{0, 0, 0}});
    add_row('{1, 12'd0, 12'd0, 8'd255, 16'hFFFF, 0, 0, '{0, 0, 0}});
    // zero focal length: each sign of the offset and a zero offset
    add_row('{2, 12'd0, 12'hFFF, 8'd0, 16'd1000, 0, 0, '{0, 0, 0}});
    add_row('{2, 12'hFFF, 12'd0, 8'd0, 16'd1000, 0, 0, '{0, 0, 0}});
    add_row('{2, 12'd320, 12'd240, 8'd0, 16'd1000, 0, 0, '{0, 0, 0}});
    add_row('{2, 12'd320, 12'd240, 8'd0, 16'd0, 1, 0, '{0, 0, 0}});
    // inverted range rejects all
    add_row('{3, 12'd320, 12'd240, 8'd1, 16'd3000, 1, 0, '{0, 0, 0}});
    add_row('{3, 12'd10, 12'd20, 8'd1, 16'd1000, 1, 0, '{0, 0, 0}});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    cur_set = 0;
    foreach (pixel_table[i]) begin
      if (pixel_table[i].cfg_set != cur_set) begin
        s_tvalid <= 1'b0;
        settle();
        cur_set = pixel_table[i].cfg_set;
        apply_cfg(cfg_sets[cur_set]);
      end
      // hints change with the item, after the scoreboard has read the previous ones
      cur_typed <= pixel_table[i].typed;
      cur_hit <= pixel_table[i].hit;
      cur_pt <= pixel_table[i].pt;
      send_pixel(pixel_table[i].col, pixel_table[i].row, pixel_table[i].label,
                 pixel_table[i].raw);
    end
    s_tvalid <= 1'b0;
    cur_typed <= 1'b0;

    // random phases, each with its own camera setup and one of four idle patterns
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      if (phase == 0) begin
        rc = cfg_sets[0];
      end else begin
        rc.label = 8'($urandom_range(255));
        rc.scale = 24'($urandom_range(24'hFFFFFF) >> $urandom_range(4, 12));
        rc.zmin = 24'($urandom_range(20000));
        rc.zmax = 24'($urandom_range(24'h7FFFFF, 24'hFFFFFF));
        rc.fx = 16'($urandom_range(16, 16'hFFFF));
        rc.fy = 16'($urandom_range(16, 16'hFFFF));
        rc.cx = 16'($urandom_range(16'hFFFF));
        rc.cy = 16'($urandom_range(16'hFFFF));
      end
      apply_cfg(rc);
      case (phase % 4)
        0: begin tx_idle = 0; rx_stall = 0; end
        1: begin tx_idle = 56; rx_stall = 0; end
        2: begin tx_idle = 0; rx_stall = 56; end
        default: begin tx_idle = 15; rx_stall = 15; end
      endcase
      // long receiver hold-off while pixels keep coming
      if (phase == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly pixels of the target object, the rest random noise
        if ($urandom_range(99) < 75) begin
          lbl = cam.label;
          raw = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(16'hFFFF));
        end else begin
          lbl = 8'($urandom_range(255));
          raw = 16'($urandom_range(16'hFFFF));
        end
        send_pixel(12'($urandom_range(12'hFFF)), 12'($urandom_range(12'hFFF)), lbl, raw);
      end
      s_tvalid <= 1'b0;
    end

    tx_idle = 0;
    rx_stall = 0;
    settle();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[masked_depth_unprojection.f]
src/mdu_pkg.sv
src/masked_depth_unprojection.sv
sim/tb_top.sv
